// File: rtl/lgi_pkg.sv
// Shared types and constants for the Langevin GJF integrator step core.
// No dependencies; every other file imports this package.
`default_nettype none
package lgi_pkg;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THERMAL_ENERGY = 2'd1;

  // Reset values, 1.0 in unsigned Q16.16
  localparam logic [31:0] TIME_STEP_RST      = 32'd65536;
  localparam logic [31:0] THERMAL_ENERGY_RST = 32'd65536;

  // Iteration counts of the pipelined digit units
  localparam int unsigned DIV_B_STEPS = 17;  // quotient bits of b
  localparam int unsigned SQRT_STEPS  = 32;  // root bits of the noise scale
  localparam int unsigned DIV_D_STEPS = 41;  // quotient bits of the position delta

  // Intermediate caps
  localparam logic [40:0] DELTA_CAP = {1'b1, 40'd0};
  localparam logic [60:0] T2_CAP    = {1'b1, 60'd0};

  // Input item
  typedef struct packed {
    logic               kind;
    logic signed [31:0] position;
    logic signed [31:0] momentum;
    logic signed [31:0] force_old;
    logic signed [31:0] force_new;
    logic signed [15:0] noise_sample;
    logic        [31:0] friction;
    logic        [31:0] mass;
    logic               atom_fixed;
    logic               component_locked;
  } lgi_in_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] new_position;
    logic signed [31:0] new_momentum;
    logic signed [31:0] kept_force;
    logic               saturated;
  } lgi_out_t;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [31:0] time_step;
    logic [31:0] thermal_energy;
  } lgi_cfg_t;

  // Per-item context carried down the pipeline; forces and noise already
  // zeroed for a locked component, mass already forced nonzero
  typedef struct packed {
    logic               kind;
    logic               fixed;
    logic               locked;
    logic signed [31:0] position;
    logic signed [31:0] momentum;
    logic signed [31:0] force_old;
    logic signed [31:0] force_new;
    logic signed [15:0] noise;
    logic        [31:0] mass;
  } lgi_ctx_t;

endpackage
`default_nettype wire

// File: rtl/lgi_in_if.sv
// Input channel of the integrator core: valid/ready plus one input item.
// Depends on lgi_pkg.
`default_nettype none
interface lgi_in_if import lgi_pkg::*; ();
  logic    valid;
  logic    ready;
  lgi_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/lgi_out_if.sv
// Result channel of the integrator core: valid/ready plus one result item.
// Depends on lgi_pkg.
`default_nettype none
interface lgi_out_if import lgi_pkg::*; ();
  logic     valid;
  logic     ready;
  lgi_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/lgi_pipe.sv
// Datapath pipeline of the integrator core: coefficient divider, noise scale
// square root, both half-step updates and saturation. Depends on lgi_pkg.
`default_nettype none
module lgi_pipe import lgi_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     up_valid,
  input  wire lgi_in_t  up_data,
  input  wire lgi_cfg_t cfg,
  output logic          res_valid,
  output lgi_out_t      res_data
);

  typedef struct packed {
    lgi_ctx_t    ctx;
    logic [63:0] fd;
  } st1_t;

  typedef struct packed {
    lgi_ctx_t    ctx;
    logic [65:0] div_n;
    logic [64:0] div_d;
    logic [63:0] kt_lo;
    logic [63:0] kt_hi;
  } st2_t;

  typedef struct packed {
    lgi_ctx_t    ctx;
    logic        ssat;
    logic [63:0] xsh;
    logic [33:0] srem;
    logic [31:0] root;
    logic [64:0] drem;
    logic [64:0] dden;
    logic [16:0] dlo;
    logic [16:0] quot;
  } sq_t;

  typedef struct packed {
    lgi_ctx_t           ctx;
    logic               ssat;
    logic        [16:0] b;
    logic signed [48:0] beta;
    logic        [48:0] bd;
    logic signed [64:0] dtfo;
    logic signed [50:0] afo;
    logic signed [50:0] ap;
  } st4_t;

  typedef struct packed {
    lgi_ctx_t           ctx;
    logic               ssat;
    logic        [48:0] bd;
    logic signed [65:0] t;
    logic signed [51:0] g;
    logic signed [66:0] bbeta;
    logic signed [50:0] ap;
  } st5_t;

  typedef struct packed {
    lgi_ctx_t           ctx;
    logic               ssat;
    logic        [48:0] bd;
    logic        [61:0] mag;
    logic               tneg;
    logic        [49:0] gm;
    logic               gneg;
    logic signed [63:0] acc;
  } st6_t;

  typedef struct packed {
    lgi_ctx_t           ctx;
    logic               ssat;
    logic               tneg;
    logic               gneg;
    logic signed [63:0] acc;
    logic        [55:0] pp_ll;
    logic        [55:0] pp_lh;
    logic        [54:0] pp_hl;
    logic        [54:0] pp_hh;
    logic        [56:0] pg_l;
    logic        [56:0] pg_h;
  } st7_t;

  typedef struct packed {
    lgi_ctx_t           ctx;
    logic               ssat;
    logic               tneg;
    logic               gneg;
    logic signed [63:0] acc;
    logic       [111:0] prod;
    logic        [82:0] prod_g;
  } st8_t;

  typedef struct packed {
    lgi_ctx_t           ctx;
    logic               ssat;
    logic               tneg;
    logic               gneg;
    logic signed [63:0] acc;
    logic        [82:0] quo_n;
    logic        [60:0] t2;
    logic               t2sat;
  } st9_t;

  typedef struct packed {
    lgi_ctx_t           ctx;
    logic               ssat;
    logic               tneg;
    logic               ovf;
    logic               t2sat;
    logic signed [63:0] sum;
    logic        [31:0] rem;
    logic        [40:0] dlo;
    logic        [40:0] q;
  } dv_t;

  localparam logic signed [42:0] POS_MAX = 43'sd2147483647;
  localparam logic signed [42:0] POS_MIN = -43'sd2147483648;
  localparam logic signed [63:0] MOM_MAX = 64'sd2147483647;
  localparam logic signed [63:0] MOM_MIN = -64'sd2147483648;

  st1_t s1_r, s1_nxt;
  st2_t s2_r, s2_nxt;
  st4_t s4_r, s4_nxt;
  st5_t s5_r, s5_nxt;
  st6_t s6_r, s6_nxt;
  st7_t s7_r, s7_nxt;
  st8_t s8_r, s8_nxt;
  st9_t s9_r, s9_nxt;
  lgi_out_t res_r, res_nxt;
  logic s1_v_r, s2_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r, s9_v_r, res_v_r;

  sq_t  sq_r   [0:SQRT_STEPS];
  logic sq_v_r [0:SQRT_STEPS];
  dv_t  dv_r   [0:DIV_D_STEPS];
  logic dv_v_r [0:DIV_D_STEPS];

  // Stage 1: context capture, friction * dt
  always_comb begin
    s1_nxt.ctx.kind     = up_data.kind;
    s1_nxt.ctx.fixed    = up_data.atom_fixed;
    s1_nxt.ctx.locked   = up_data.component_locked;
    s1_nxt.ctx.position = up_data.position;
    s1_nxt.ctx.momentum = up_data.momentum;
    s1_nxt.ctx.force_old = up_data.component_locked ? 32'sd0 : up_data.force_old;
    s1_nxt.ctx.force_new = up_data.component_locked ? 32'sd0 : up_data.force_new;
    s1_nxt.ctx.noise    = up_data.component_locked ? 16'sd0 : up_data.noise_sample;
    s1_nxt.ctx.mass     = (up_data.mass == 32'd0) ? 32'd1 : up_data.mass;
    s1_nxt.fd           = up_data.friction * cfg.time_step;
  end

  // Stage 2: divider operands for b = round(m*2^32 / D), fd * kT partials
  logic [63:0] den2;
  always_comb begin
    den2          = {16'd0, s1_r.ctx.mass, 16'd0} + {1'b0, s1_r.fd[63:1]};
    s2_nxt.ctx    = s1_r.ctx;
    s2_nxt.div_n  = {1'b0, s1_r.ctx.mass, 33'd0} + {2'b00, den2};
    s2_nxt.div_d  = {den2, 1'b0};
    s2_nxt.kt_lo  = s1_r.fd[31:0] * cfg.thermal_energy;
    s2_nxt.kt_hi  = s1_r.fd[63:32] * cfg.thermal_energy;
  end

  // Stage 3: square root operand with saturation, divider start
  logic [95:0] x96;
  sq_t         sq0_nxt;
  always_comb begin
    x96          = {s2_r.kt_hi, 32'd0} + {32'd0, s2_r.kt_lo};
    sq0_nxt.ctx  = s2_r.ctx;
    sq0_nxt.ssat = |x96[95:79];
    sq0_nxt.xsh  = sq0_nxt.ssat ? {64{1'b1}} : x96[78:15];
    sq0_nxt.srem = '0;
    sq0_nxt.root = '0;
    sq0_nxt.drem = {16'd0, s2_r.div_n[65:17]};
    sq0_nxt.dden = s2_r.div_d;
    sq0_nxt.dlo  = s2_r.div_n[16:0];
    sq0_nxt.quot = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r      <= s1_nxt;
      s2_r      <= s2_nxt;
      sq_r[0]   <= sq0_nxt;
    end
  end

  // Root digit per stage; the first stages also produce one bit of b
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq
    sq_t         step_nxt;
    logic [35:0] sh;
    logic [35:0] trial;
    logic [65:0] dsh;
    logic        dge;
    always_comb begin
      step_nxt = sq_r[k];
      sh       = {sq_r[k].srem, sq_r[k].xsh[63:62]};
      trial    = {2'b00, sq_r[k].root, 2'b01};
      step_nxt.xsh = {sq_r[k].xsh[61:0], 2'b00};
      if (sh >= trial) begin
        step_nxt.srem = 34'(sh - trial);
        step_nxt.root = {sq_r[k].root[30:0], 1'b1};
      end else begin
        step_nxt.srem = sh[33:0];
        step_nxt.root = {sq_r[k].root[30:0], 1'b0};
      end
      dsh = {sq_r[k].drem, sq_r[k].dlo[16]};
      dge = dsh >= {1'b0, sq_r[k].dden};
      if (k < DIV_B_STEPS) begin
        step_nxt.drem = dge ? 65'(dsh - {1'b0, sq_r[k].dden}) : dsh[64:0];
        step_nxt.dlo  = {sq_r[k].dlo[15:0], 1'b0};
        step_nxt.quot = {sq_r[k].quot[15:0], dge};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k+1] <= step_nxt;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end
  end

  // Stage 4: a = 2b - 1, noise term, products with dt and a
  sq_t                sqe;
  logic signed [18:0] a4;
  logic signed [31:0] p4;
  always_comb begin
    sqe          = sq_r[SQRT_STEPS];
    a4           = $signed({1'b0, sqe.quot, 1'b0}) - 19'sd65536;
    p4           = sqe.ctx.locked ? 32'sd0 : sqe.ctx.momentum;
    s4_nxt.ctx   = sqe.ctx;
    s4_nxt.ssat  = sqe.ssat;
    s4_nxt.b     = sqe.quot;
    s4_nxt.beta  = $signed({1'b0, sqe.root}) * $signed(sqe.ctx.noise);
    s4_nxt.bd    = sqe.quot * cfg.time_step;
    s4_nxt.dtfo  = $signed({1'b0, cfg.time_step}) * $signed(sqe.ctx.force_old);
    s4_nxt.afo   = a4 * $signed(sqe.ctx.force_old);
    s4_nxt.ap    = a4 * p4;
  end

  // Stage 5: position-half sum T, momentum force sum G, b * beta
  logic signed [65:0] pe5;
  logic signed [64:0] dtfo5;
  logic signed [51:0] fn5;
  always_comb begin
    pe5          = s4_r.ctx.locked ? 66'sd0 : $signed(s4_r.ctx.momentum);
    dtfo5        = ($signed(s4_r.dtfo) + 65'sd4) >>> 3;
    fn5          = $signed(s4_r.ctx.force_new);
    s5_nxt.ctx   = s4_r.ctx;
    s5_nxt.ssat  = s4_r.ssat;
    s5_nxt.bd    = s4_r.bd;
    s5_nxt.t     = (pe5 <<< 13) + dtfo5 + $signed(s4_r.beta);
    s5_nxt.g     = $signed(s4_r.afo) + (fn5 <<< 16);
    s5_nxt.bbeta = $signed({1'b0, s4_r.b}) * $signed(s4_r.beta);
    s5_nxt.ap    = s4_r.ap;
  end

  // Stage 6: magnitudes and signs, rounded noise term added to a*p
  logic signed [65:0] tabs6;
  logic signed [51:0] gabs6;
  logic signed [66:0] bbr6;
  logic signed [63:0] bb64;
  logic signed [63:0] ap64;
  always_comb begin
    tabs6       = s5_r.t[65] ? -s5_r.t : s5_r.t;
    gabs6       = s5_r.g[51] ? -s5_r.g : s5_r.g;
    bbr6        = ($signed(s5_r.bbeta) + 67'sd2048) >>> 12;
    bb64        = $signed(bbr6[63:0]);
    ap64        = $signed(s5_r.ap);
    s6_nxt.ctx  = s5_r.ctx;
    s6_nxt.ssat = s5_r.ssat;
    s6_nxt.bd   = s5_r.bd;
    s6_nxt.mag  = tabs6[61:0];
    s6_nxt.tneg = s5_r.t[65];
    s6_nxt.gm   = gabs6[49:0];
    s6_nxt.gneg = s5_r.g[51];
    s6_nxt.acc  = ap64 + bb64;
  end

  // Stage 7: partial products of b*dt*|T| and dt*|G|
  always_comb begin
    s7_nxt.ctx   = s6_r.ctx;
    s7_nxt.ssat  = s6_r.ssat;
    s7_nxt.tneg  = s6_r.tneg;
    s7_nxt.gneg  = s6_r.gneg;
    s7_nxt.acc   = s6_r.acc;
    s7_nxt.pp_ll = s6_r.bd[24:0] * s6_r.mag[30:0];
    s7_nxt.pp_lh = s6_r.bd[24:0] * s6_r.mag[61:31];
    s7_nxt.pp_hl = s6_r.bd[48:25] * s6_r.mag[30:0];
    s7_nxt.pp_hh = s6_r.bd[48:25] * s6_r.mag[61:31];
    s7_nxt.pg_l  = cfg.time_step * s6_r.gm[24:0];
    s7_nxt.pg_h  = cfg.time_step * s6_r.gm[49:25];
  end

  // Stage 8: sum the partials
  always_comb begin
    s8_nxt.ctx    = s7_r.ctx;
    s8_nxt.ssat   = s7_r.ssat;
    s8_nxt.tneg   = s7_r.tneg;
    s8_nxt.gneg   = s7_r.gneg;
    s8_nxt.acc    = s7_r.acc;
    s8_nxt.prod   = 112'(s7_r.pp_ll) + (112'(s7_r.pp_lh) << 31)
                  + (112'(s7_r.pp_hl) << 25) + (112'(s7_r.pp_hh) << 56);
    s8_nxt.prod_g = 83'(s7_r.pg_l) + (83'(s7_r.pg_h) << 25);
  end

  // Stage 9: half-up bias for the delta quotient, rounded and capped t2
  logic [111:0] psum9;
  logic  [82:0] pgr9;
  logic  [65:0] t2f9;
  always_comb begin
    psum9        = s8_r.prod + (112'(s8_r.ctx.mass) << 28);
    pgr9         = s8_r.prod_g + 83'd65536;
    t2f9         = pgr9[82:17];
    s9_nxt.ctx   = s8_r.ctx;
    s9_nxt.ssat  = s8_r.ssat;
    s9_nxt.tneg  = s8_r.tneg;
    s9_nxt.gneg  = s8_r.gneg;
    s9_nxt.acc   = s8_r.acc;
    s9_nxt.quo_n = psum9[111:29];
    s9_nxt.t2sat = t2f9 > 66'(T2_CAP);
    s9_nxt.t2    = s9_nxt.t2sat ? T2_CAP : t2f9[60:0];
  end

  // Stage 10: quotient overflow check, divider start, momentum sum
  dv_t                dv0_nxt;
  logic signed [63:0] t2v;
  always_comb begin
    t2v           = $signed({3'b000, s9_r.t2});
    dv0_nxt.ctx   = s9_r.ctx;
    dv0_nxt.ssat  = s9_r.ssat;
    dv0_nxt.tneg  = s9_r.tneg;
    dv0_nxt.t2sat = s9_r.t2sat;
    dv0_nxt.ovf   = s9_r.quo_n[82:41] >= 42'(s9_r.ctx.mass);
    dv0_nxt.sum   = s9_r.acc + (s9_r.gneg ? -t2v : t2v);
    dv0_nxt.rem   = s9_r.quo_n[72:41];
    dv0_nxt.dlo   = s9_r.quo_n[40:0];
    dv0_nxt.q     = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r     <= s4_nxt;
      s5_r     <= s5_nxt;
      s6_r     <= s6_nxt;
      s7_r     <= s7_nxt;
      s8_r     <= s8_nxt;
      s9_r     <= s9_nxt;
      dv_r[0]  <= dv0_nxt;
    end
  end

  // One delta quotient bit per stage, divisor is the mass
  for (genvar k = 0; k < DIV_D_STEPS; k++) begin : g_dv
    dv_t         step_nxt;
    logic [32:0] sh;
    logic        ge;
    always_comb begin
      step_nxt     = dv_r[k];
      sh           = {dv_r[k].rem, dv_r[k].dlo[40]};
      ge           = sh >= {1'b0, dv_r[k].ctx.mass};
      step_nxt.rem = ge ? 32'(sh - {1'b0, dv_r[k].ctx.mass}) : sh[31:0];
      step_nxt.dlo = {dv_r[k].dlo[39:0], 1'b0};
      step_nxt.q   = {dv_r[k].q[39:0], ge};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k+1] <= step_nxt;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end
  end

  // Final stage: cap delta, clamp both results, pick by kind
  dv_t                dve;
  logic               dsat;
  logic        [40:0] dmag;
  logic signed [42:0] dval;
  logic signed [42:0] npf;
  logic signed [63:0] nmf;
  logic               ssat_used;
  logic               clp0;
  logic               clp1;
  logic signed [31:0] np0;
  logic signed [31:0] nm1;
  always_comb begin
    dve       = dv_r[DIV_D_STEPS];
    dsat      = dve.ovf || (dve.q > DELTA_CAP);
    dmag      = dsat ? DELTA_CAP : dve.q;
    dval      = $signed({2'b00, dmag});
    npf       = $signed(dve.ctx.position) + (dve.tneg ? -dval : dval);
    nmf       = (dve.sum + 64'sd32768) >>> 16;
    ssat_used = dve.ssat && (dve.ctx.noise != 16'sd0);
    clp0      = (npf > POS_MAX) || (npf < POS_MIN);
    clp1      = (nmf > MOM_MAX) || (nmf < MOM_MIN);
    np0       = (npf > POS_MAX) ? 32'sh7fffffff :
                (npf < POS_MIN) ? 32'sh80000000 : npf[31:0];
    nm1       = (nmf > MOM_MAX) ? 32'sh7fffffff :
                (nmf < MOM_MIN) ? 32'sh80000000 : nmf[31:0];
    if (dve.ctx.fixed) begin
      res_nxt.new_position = dve.ctx.position;
      res_nxt.new_momentum = '0;
      res_nxt.kept_force   = '0;
      res_nxt.saturated    = 1'b0;
    end else if (!dve.ctx.kind) begin
      res_nxt.new_position = np0;
      res_nxt.new_momentum = dve.ctx.momentum;
      res_nxt.kept_force   = dve.ctx.force_old;
      res_nxt.saturated    = ssat_used || dsat || clp0;
    end else begin
      res_nxt.new_position = dve.ctx.position;
      res_nxt.new_momentum = nm1;
      res_nxt.kept_force   = '0;
      res_nxt.saturated    = ssat_used || dve.t2sat || clp1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  // Valid bits of the fixed stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      sq_v_r[0] <= 1'b0;
      s4_v_r    <= 1'b0;
      s5_v_r    <= 1'b0;
      s6_v_r    <= 1'b0;
      s7_v_r    <= 1'b0;
      s8_v_r    <= 1'b0;
      s9_v_r    <= 1'b0;
      dv_v_r[0] <= 1'b0;
      res_v_r   <= 1'b0;
    end else if (en) begin
      s1_v_r    <= up_valid;
      s2_v_r    <= s1_v_r;
      sq_v_r[0] <= s2_v_r;
      s4_v_r    <= sq_v_r[SQRT_STEPS];
      s5_v_r    <= s4_v_r;
      s6_v_r    <= s5_v_r;
      s7_v_r    <= s6_v_r;
      s8_v_r    <= s7_v_r;
      s9_v_r    <= s8_v_r;
      dv_v_r[0] <= s9_v_r;
      res_v_r   <= dv_v_r[DIV_D_STEPS];
    end
  end

  assign res_valid = res_v_r;
  assign res_data  = res_r;

endmodule
`default_nettype wire

// File: rtl/langevin_gjf_integrator_step_core.sv
// Top level of the Langevin GJF integrator step core: configuration
// registers, datapath pipeline and output register with skid stage.
// Depends on lgi_pkg, lgi_in_if, lgi_out_if and lgi_pipe.
`default_nettype none
// One atom component enters per clock while the skid stage is empty; the
// pipeline length is set by the 32-stage square root of the noise scale and
// the 41-stage quotient of the position delta, which run as one bit or root
// digit per pipeline stage. A stalled output holds the pipeline after one extra
// item lands in the skid stage, and nothing is lost. The user must write
// time_step and thermal_energy through the cfg port only while no item is in
// flight, not enforced; index values beyond the register list are ignored.
module langevin_gjf_integrator_step_core import lgi_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  lgi_in_if.sink                    in_chan,
  lgi_out_if.source                 out_chan,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  lgi_cfg_t cfg_r;
  logic     en;
  logic     res_valid;
  lgi_out_t res_data;
  logic     out_v_r;
  lgi_out_t out_r;
  logic     skid_v_r;
  lgi_out_t skid_r;
  logic     out_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_step      <= TIME_STEP_RST;
      cfg_r.thermal_energy <= THERMAL_ENERGY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP:      cfg_r.time_step      <= cfg_data;
        REG_THERMAL_ENERGY: cfg_r.thermal_energy <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline moves whenever the skid stage is free
  assign en            = !skid_v_r;
  assign in_chan.ready = en;
  assign out_take      = out_v_r && out_chan.ready;

  lgi_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .up_valid  (in_chan.valid),
    .up_data   (in_chan.data),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // Output register and skid stage, control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_take) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= res_valid && en;
      end
    end else if (res_valid && en) begin
      skid_v_r <= 1'b1;
    end
  end

  // Output register and skid stage, item data
  always_ff @(posedge clk) begin
    if (!out_v_r || out_take) begin
      out_r <= skid_v_r ? skid_r : res_data;
    end else if (res_valid && en) begin
      skid_r <= res_data;
    end
  end

  assign out_chan.valid = out_v_r;
  assign out_chan.data  = out_r;

`ifndef ASSERT_OFF
  // The skid stage only holds an item behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds an item while the output is empty");

  // The skid stage fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_chan.ready))
    else $error("skid filled without an output stall");

  // A drained skid item becomes the next output item
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_chan.ready) |=> (out_v_r && !skid_v_r))
    else $error("skid item not moved to the output");
`endif

endmodule
`default_nettype wire
